// ===== sv/tws_pkg.sv =====
// Shared types and constants for the two-wire serial master.
// Used by tws_cfg, tws_core and two_wire_serial_master.
package tws_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int REPLY_BYTES = 6;
    localparam int TICK_W      = 16;
    localparam int CNT_W       = 5;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [CNT_W-1:0] FRAME_BYTES_C = CNT_W'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] REPLY_BYTES_C = CNT_W'(REPLY_BYTES);

    localparam logic [1:0] REG_HALF_BIT   = 2'd0;
    localparam logic [1:0] REG_START      = 2'd1;
    localparam logic [1:0] REG_TURNAROUND = 2'd2;

    localparam logic [TICK_W-1:0] HALF_BIT_RESET   = 16'd5;
    localparam logic [TICK_W-1:0] START_RESET      = 16'd100;
    localparam logic [TICK_W-1:0] TURNAROUND_RESET = 16'd10;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_SEND  = 3'd2,
        PH_TURN  = 3'd3,
        PH_RECV  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] half_bit_ticks;
        logic [TICK_W-1:0] start_ticks;
        logic [TICK_W-1:0] turnaround_ticks;
    } cfg_t;

    typedef struct packed {
        op_t              operation;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       byte_value;
        logic [CNT_W-1:0] send_count;
        logic [CNT_W-1:0] receive_count;
        logic             dat_in;
    } item_t;

    typedef struct packed {
        logic             clk_level;
        logic             dat_drive_low;
        logic             busy_res;
        logic             rx_valid;
        logic [IDX_W-1:0] rx_index;
        logic [7:0]       rx_byte;
        logic             rx_last;
        logic             length_error;
        logic             done_res;
    } result_t;

endpackage

// ===== sv/tws_cfg.sv =====
// Timing register file of the two-wire serial master.
// Depends on tws_pkg.
module tws_cfg
    import tws_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [TICK_W-1:0] cfg_wdata,
    output cfg_t              cfg
);

    logic [TICK_W-1:0] half_bit_reg;
    logic [TICK_W-1:0] start_reg;
    logic [TICK_W-1:0] turn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_bit_reg <= HALF_BIT_RESET;
            start_reg    <= START_RESET;
            turn_reg     <= TURNAROUND_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HALF_BIT:   half_bit_reg <= cfg_wdata;
                REG_START:      start_reg    <= cfg_wdata;
                REG_TURNAROUND: turn_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.half_bit_ticks   = half_bit_reg;
    assign cfg.start_ticks      = start_reg;
    assign cfg.turnaround_ticks = turn_reg;

endmodule

// ===== sv/tws_core.sv =====
// Line sequencer of the two-wire serial master: state, transmit buffer
// and the per-item step logic. Depends on tws_pkg.
module tws_core
    import tws_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    item_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [CNT_W-1:0]  byte_pos_reg, byte_pos_next;
    logic [2:0]        bit_pos_reg, bit_pos_next;
    logic              bit_half_reg, bit_half_next;
    logic [7:0]        shift_reg, shift_next;
    logic [CNT_W-1:0]  scnt_reg, scnt_next;
    logic [CNT_W-1:0]  rcnt_reg, rcnt_next;
    logic              clk_reg, clk_next;
    logic              dat_low_reg, dat_low_next;
    logic [7:0]        buf_reg [FRAME_BYTES];

    logic              buf_we;
    logic [TICK_W-1:0] seg_raw;
    logic [TICK_W-1:0] seg_len;
    logic [TICK_W:0]   tick_inc;
    logic              seg_hit;
    logic [CNT_W-1:0]  pos_inc;
    logic [CNT_W-1:0]  fb_pos;
    logic [7:0]        fb_val;
    logic [CNT_W-1:0]  rx_lim;
    logic [7:0]        rx_shift;

    always_comb begin
        case (phase_reg)
            PH_START: seg_raw = cfg.start_ticks;
            PH_TURN:  seg_raw = cfg.turnaround_ticks;
            default:  seg_raw = cfg.half_bit_ticks;
        endcase
        seg_len  = (seg_raw == '0) ? TICK_W'(1) : seg_raw;
        tick_inc = {1'b0, tick_reg} + (TICK_W+1)'(1);
        seg_hit  = tick_inc >= {1'b0, seg_len};
        pos_inc  = byte_pos_reg + CNT_W'(1);
        fb_pos   = (phase_reg == PH_START) ? '0 : pos_inc;
        fb_val   = (fb_pos < scnt_reg && fb_pos < FRAME_BYTES_C) ?
                   buf_reg[fb_pos[IDX_W-1:0]] : 8'd0;
        rx_lim   = (rcnt_reg < REPLY_BYTES_C) ? rcnt_reg : REPLY_BYTES_C;
        rx_shift = {shift_reg[6:0], item.dat_in};
    end

    always_comb begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        byte_pos_next = byte_pos_reg;
        bit_pos_next  = bit_pos_reg;
        bit_half_next = bit_half_reg;
        shift_next    = shift_reg;
        scnt_next     = scnt_reg;
        rcnt_next     = rcnt_reg;
        clk_next      = clk_reg;
        dat_low_next  = dat_low_reg;
        buf_we        = 1'b0;
        result        = '0;

        case (item.operation)
            OP_LOAD: begin
                buf_we = (phase_reg == PH_IDLE);
            end
            OP_START: begin
                if (phase_reg == PH_IDLE) begin
                    if (item.send_count > FRAME_BYTES_C ||
                        item.receive_count > FRAME_BYTES_C) begin
                        result.length_error = 1'b1;
                    end else begin
                        scnt_next    = item.send_count;
                        rcnt_next    = item.receive_count;
                        phase_next   = PH_START;
                        tick_next    = '0;
                        clk_next     = 1'b0;
                        dat_low_next = 1'b0;
                    end
                end
            end
            OP_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    tick_next = seg_hit ? '0 : tick_inc[TICK_W-1:0];
                end
                case (phase_reg)
                    PH_START: begin
                        if (seg_hit) begin
                            phase_next    = PH_SEND;
                            byte_pos_next = '0;
                            bit_pos_next  = 3'd7;
                            bit_half_next = 1'b0;
                            shift_next    = fb_val;
                            clk_next      = 1'b0;
                            dat_low_next  = ~fb_val[7];
                        end
                    end
                    PH_SEND: begin
                        if (seg_hit) begin
                            if (!bit_half_reg) begin
                                bit_half_next = 1'b1;
                                clk_next      = 1'b1;
                            end else begin
                                bit_half_next = 1'b0;
                                shift_next    = {shift_reg[6:0], 1'b0};
                                if (bit_pos_reg != 3'd0) begin
                                    bit_pos_next = bit_pos_reg - 3'd1;
                                    clk_next     = 1'b0;
                                    dat_low_next = ~shift_reg[6];
                                end else begin
                                    bit_pos_next = 3'd7;
                                    if (pos_inc >= FRAME_BYTES_C) begin
                                        phase_next    = PH_TURN;
                                        byte_pos_next = '0;
                                        clk_next      = 1'b0;
                                        dat_low_next  = 1'b0;
                                    end else begin
                                        byte_pos_next = pos_inc;
                                        shift_next    = fb_val;
                                        clk_next      = 1'b0;
                                        dat_low_next  = ~fb_val[7];
                                    end
                                end
                            end
                        end
                    end
                    PH_TURN: begin
                        if (seg_hit) begin
                            phase_next    = PH_RECV;
                            byte_pos_next = '0;
                            bit_pos_next  = 3'd7;
                            bit_half_next = 1'b0;
                            shift_next    = 8'd0;
                            clk_next      = 1'b1;
                            dat_low_next  = 1'b0;
                        end
                    end
                    PH_RECV: begin
                        if (seg_hit) begin
                            if (!bit_half_reg) begin
                                shift_next    = rx_shift;
                                bit_half_next = 1'b1;
                                clk_next      = 1'b0;
                                if (bit_pos_reg == 3'd0 && byte_pos_reg < rx_lim) begin
                                    result.rx_valid = 1'b1;
                                    result.rx_index = byte_pos_reg[IDX_W-1:0];
                                    result.rx_byte  = rx_shift;
                                    result.rx_last  = (pos_inc == rx_lim);
                                end
                            end else begin
                                bit_half_next = 1'b0;
                                clk_next      = 1'b1;
                                if (bit_pos_reg != 3'd0) begin
                                    bit_pos_next = bit_pos_reg - 3'd1;
                                end else begin
                                    bit_pos_next = 3'd7;
                                    shift_next   = 8'd0;
                                    if (pos_inc >= REPLY_BYTES_C) begin
                                        phase_next      = PH_IDLE;
                                        byte_pos_next   = '0;
                                        result.done_res = 1'b1;
                                    end else begin
                                        byte_pos_next = pos_inc;
                                    end
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        result.clk_level     = clk_next;
        result.dat_drive_low = dat_low_next;
        result.busy_res      = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            byte_pos_reg <= '0;
            bit_pos_reg  <= 3'd7;
            bit_half_reg <= 1'b0;
            shift_reg    <= 8'd0;
            scnt_reg     <= '0;
            rcnt_reg     <= '0;
            clk_reg      <= 1'b1;
            dat_low_reg  <= 1'b0;
        end else if (item_en) begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            byte_pos_reg <= byte_pos_next;
            bit_pos_reg  <= bit_pos_next;
            bit_half_reg <= bit_half_next;
            shift_reg    <= shift_next;
            scnt_reg     <= scnt_next;
            rcnt_reg     <= rcnt_next;
            clk_reg      <= clk_next;
            dat_low_reg  <= dat_low_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                buf_reg[i] <= 8'd0;
            end
        end else if (item_en && buf_we) begin
            buf_reg[item.byte_index] <= item.byte_value;
        end
    end

endmodule

// ===== sv/two_wire_serial_master.sv =====
// Top level of the two-wire serial master: input register, sequencer,
// result register and timing registers. Depends on tws_pkg, tws_cfg, tws_core.
//
//  channel   direction  payload
//  s_*       in         tuser: operation; tdata: index, value, counts, dat_in
//  m_*       out        tdata: line levels, status, received byte; tlast: rx_last
//  cfg_*     in         write of one 16-bit timing register
//
// The sequencer steps each item combinationally; the result register loads
// when the item leaves the input register. One item per cycle is sustained while m_tready is high.
// Reset is synchronous to aclk and active low; it empties both registers.
// A stalled result stays in the output register while one more item waits
// in the input register; s_tready drops only when both are full.
module two_wire_serial_master
    import tws_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_tuser,   // operation
    input  logic [23:0]       s_tdata,   // byte_index, byte_value, send_count,
                                         // receive_count, dat_in, pad
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // clk_level, dat_drive_low, busy_res,
                                         // rx_valid, rx_index, rx_byte,
                                         // length_error, done_res, pad
    output logic              m_tlast,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [TICK_W-1:0] cfg_wdata
);

    item_t   in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t step_result;
    cfg_t    cfg;
    item_t   s_item;
    logic    advance;

    assign s_item.operation     = op_t'(s_tuser);
    assign s_item.byte_index    = s_tdata[3:0];
    assign s_item.byte_value    = s_tdata[11:4];
    assign s_item.send_count    = s_tdata[16:12];
    assign s_item.receive_count = s_tdata[21:17];
    assign s_item.dat_in        = s_tdata[22];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tws_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tws_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.rx_last;
    assign m_tdata  = {6'd0,
                       out_reg.done_res,
                       out_reg.length_error,
                       out_reg.rx_byte,
                       out_reg.rx_index,
                       out_reg.rx_valid,
                       out_reg.busy_res,
                       out_reg.dat_drive_low,
                       out_reg.clk_level};

endmodule

// ===== sv/tws_checker.sv =====
// Port-level checks on the result channel of the two-wire serial master,
// bound to two_wire_serial_master. No package dependency.
module tws_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_last_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[3] && m_tdata[2])
        else $error("last marker without a received byte");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17] |-> !m_tdata[2] && m_tdata[0] && !m_tdata[1])
        else $error("stop reached but lines not idle");

    a_error_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[16] |-> !m_tdata[2] && !m_tdata[3])
        else $error("length error while a transfer runs");

endmodule

bind two_wire_serial_master tws_checker u_tws_checker (.*);
